[rtl/assert_macros.svh]
// assertion helper macros for the path stack checker
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PSWS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// expression must never be true outside reset
`define PSWS_NEVER(name, clk, rst_n, expr) \
  `PSWS_ASSERT(name, clk, rst_n, !(expr))

`endif

[rtl/psws_pkg.sv]
// shared types, codes and defaults for the path stack wildcard search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psws_pkg;

  localparam int unsigned PATH_DEPTH_DEF   = 64;
  localparam int unsigned BACKUP_DEPTH_DEF = 32;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_SEARCH     = 3'd2,
    OP_SET_FIRST  = 3'd3,
    OP_SET_SECOND = 3'd4,
    OP_SAVE       = 3'd5,
    OP_RESTORE    = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_FULL        = 2'd2,
    ST_BACKUP_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
    logic [FIELD_W-1:0] tag;
  } entry_t;

  // first instance in the high half
  typedef struct packed {
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
  } pair_t;

endpackage

`default_nettype wire

[rtl/psws_if.sv]
// valid/ready channel interfaces for request and response beats
// depends on psws_pkg
`timescale 1ns / 1ps
`default_nettype none

interface psws_in_if;
  import psws_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [FIELD_W-1:0]  entry_id;
  logic [FIELD_W-1:0]         first_inst;
  logic [FIELD_W-1:0]         second_inst;
  logic [FIELD_W-1:0]         clause_tag;

  modport source (
    output valid, operation, entry_id, first_inst, second_inst, clause_tag,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_id, first_inst, second_inst, clause_tag,
    output ready
  );
endinterface

interface psws_out_if;
  import psws_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [FIELD_W-1:0] top_first_inst;
  logic [FIELD_W-1:0] top_second_inst;
  logic [DEPTH_W-1:0] stack_depth;
  logic [STAT_W-1:0]  status;

  modport source (
    output valid, found, top_first_inst, top_second_inst, stack_depth, status,
    input  ready
  );
  modport sink (
    input  valid, found, top_first_inst, top_second_inst, stack_depth, status,
    output ready
  );
endinterface

`default_nettype wire

[rtl/psws_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module psws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/path_stack_wildcard_search.sv]
// path stack with wildcard search: sequencer around the path and backup rams
// depends on psws_pkg, psws_if, psws_ram
//
// usage
//   req_i carries one operation per beat (push, pop, search, set first or
//   second instance of the top entry, save, restore); rsp_o returns exactly
//   one beat per request with found, the top instance pair, depth and status.
// sequencing
//   push, set, save, ignored ops, search on an empty stack, a pop that leaves
//   the stack empty and failed restore: response is valid the cycle after the
//   request beat; one per cycle if rsp_o is ready. pop that leaves entries:
//   one path ram read for the new top. restore: backup ram read, then path
//   ram write. search: one path ram read per entry through the single read
//   port of the path ram, stopping at the first match.
// reset
//   rst_ni clears both stack counts and the sequencer; ram contents are
//   left as they are and only entries below the counts are ever read.
// stall
//   the response is held in an output register; a new request is taken
//   while a response waits only if the sink takes it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module path_stack_wildcard_search #(
  parameter int unsigned PATH_DEPTH   = psws_pkg::PATH_DEPTH_DEF,
  parameter int unsigned BACKUP_DEPTH = psws_pkg::BACKUP_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psws_in_if.sink     req_i,
  psws_out_if.source  rsp_o
);
  import psws_pkg::*;

  localparam int unsigned PAW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int unsigned PCW = $clog2(PATH_DEPTH + 1);
  localparam int unsigned BAW = (BACKUP_DEPTH > 1) ? $clog2(BACKUP_DEPTH) : 1;
  localparam int unsigned BCW = $clog2(BACKUP_DEPTH + 1);
  localparam logic [PCW-1:0] PathFull   = PCW'(PATH_DEPTH);
  localparam logic [BCW-1:0] BackupFull = BCW'(BACKUP_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_SEARCH     = 5'b00010,
    S_POP_RD     = 5'b00100,
    S_RESTORE_WR = 5'b01000,
    S_DONE       = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [PCW-1:0]   count_q, count_d;
  logic [BCW-1:0]   saved_q, saved_d;
  logic [PCW-1:0]   idx_q, idx_d;
  logic             pend_q, pend_d;
  entry_t           top_q, top_d;
  entry_t           query_q, query_d;
  logic             found_q, found_d;
  status_e          status_q, status_d;

  logic               out_valid_q, out_valid_d;
  logic               out_found_q;
  logic [FIELD_W-1:0] out_first_q;
  logic [FIELD_W-1:0] out_second_q;
  logic [DEPTH_W-1:0] out_depth_q;
  status_e            out_status_q;
  logic               load_out;

  logic               path_we;
  logic [PAW-1:0]     path_waddr;
  entry_t             path_wdata;
  logic [PAW-1:0]     path_raddr;
  entry_t             path_rdata;
  logic               bk_we;
  logic [BAW-1:0]     bk_waddr;
  pair_t              bk_wdata;
  logic [BAW-1:0]     bk_raddr;
  pair_t              bk_rdata;

  logic               in_fire;
  logic               out_free;
  logic [PCW-1:0]     count_m1;
  logic [PCW-1:0]     count_m2;
  logic [BCW-1:0]     saved_m1;
  entry_t             req_entry;
  logic               match;

  psws_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PATH_DEPTH),
    .AW    (PAW)
  ) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .raddr_i (path_raddr),
    .rdata_o (path_rdata)
  );

  psws_ram #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (BACKUP_DEPTH),
    .AW    (BAW)
  ) u_backup_ram (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .waddr_i (bk_waddr),
    .wdata_i (bk_wdata),
    .raddr_i (bk_raddr),
    .rdata_o (bk_rdata)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign in_fire     = req_i.valid && req_i.ready;

  assign count_m1 = count_q - PCW'(1);
  assign count_m2 = count_q - PCW'(2);
  assign saved_m1 = saved_q - BCW'(1);

  assign req_entry.id     = $unsigned(req_i.entry_id);
  assign req_entry.first  = req_i.first_inst;
  assign req_entry.second = req_i.second_inst;
  assign req_entry.tag    = req_i.clause_tag;

  // zero in the first, second or tag field of the query acts as a wildcard; id must match
  assign match = (path_rdata.id == query_q.id) &&
                 ((query_q.first  == '0) || (path_rdata.first  == query_q.first)) &&
                 ((query_q.second == '0) || (path_rdata.second == query_q.second)) &&
                 ((query_q.tag    == '0) || (path_rdata.tag    == query_q.tag));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    saved_d    = saved_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    top_d      = top_q;
    query_d    = query_q;
    found_d    = found_q;
    status_d   = status_q;
    load_out   = 1'b0;
    path_we    = 1'b0;
    path_waddr = count_m1[PAW-1:0];
    path_wdata = top_q;
    path_raddr = idx_q[PAW-1:0];
    bk_we      = 1'b0;
    bk_waddr   = saved_q[BAW-1:0];
    bk_wdata   = '{first: top_q.first, second: top_q.second};
    bk_raddr   = saved_m1[BAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          found_d  = 1'b0;
          status_d = ST_OK;
          load_out = 1'b1;
          case (op_e'(req_i.operation))
            OP_PUSH: begin
              if (count_q == PathFull) begin
                status_d = ST_FULL;
              end else begin
                path_we    = 1'b1;
                path_waddr = count_q[PAW-1:0];
                path_wdata = req_entry;
                top_d      = req_entry;
                count_d    = count_q + PCW'(1);
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_m1;
                if (count_m1 != '0) begin
                  path_raddr = count_m2[PAW-1:0];
                  load_out   = 1'b0;
                  state_d    = S_POP_RD;
                end
              end
            end
            OP_SEARCH: begin
              if (count_q != '0) begin
                query_d  = req_entry;
                idx_d    = '0;
                load_out = 1'b0;
                state_d  = S_SEARCH;
              end
            end
            OP_SET_FIRST: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                top_d.first = req_i.first_inst;
                path_we     = 1'b1;
                path_wdata  = top_d;
              end
            end
            OP_SET_SECOND: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                top_d.second = req_i.second_inst;
                path_we      = 1'b1;
                path_wdata   = top_d;
              end
            end
            OP_SAVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (saved_q == BackupFull) begin
                status_d = ST_BACKUP_FULL;
              end else begin
                bk_we   = 1'b1;
                saved_d = saved_q + BCW'(1);
              end
            end
            OP_RESTORE: begin
              if ((count_q == '0) || (saved_q == '0)) begin
                status_d = ST_EMPTY;
              end else begin
                saved_d  = saved_m1;
                load_out = 1'b0;
                state_d  = S_RESTORE_WR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // issue one read per cycle, compare each returned beat in the cycle after its read
        if (idx_q != count_q) begin
          pend_d = 1'b1;
          idx_d  = idx_q + PCW'(1);
        end
        if (pend_q && match) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (!pend_q && (idx_q == count_q)) begin
          state_d = S_DONE;
        end
      end
      S_POP_RD: begin
        top_d   = path_rdata;
        state_d = S_DONE;
      end
      S_RESTORE_WR: begin
        top_d.first  = bk_rdata.first;
        top_d.second = bk_rdata.second;
        path_we      = 1'b1;
        path_wdata   = top_d;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      saved_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      saved_q     <= saved_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    query_q  <= query_d;
    found_q  <= found_d;
    status_q <= status_d;
    if (load_out) begin
      out_found_q  <= found_d;
      out_first_q  <= (count_d != '0) ? top_d.first  : '0;
      out_second_q <= (count_d != '0) ? top_d.second : '0;
      out_depth_q  <= DEPTH_W'(count_d);
      out_status_q <= status_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.found           = out_found_q;
  assign rsp_o.top_first_inst  = out_first_q;
  assign rsp_o.top_second_inst = out_second_q;
  assign rsp_o.stack_depth     = out_depth_q;
  assign rsp_o.status          = out_status_q;

endmodule

`default_nettype wire

[rtl/psws_checker.sv]
// port level checks for the path stack wildcard search block, bound to the top
// depends on psws_pkg, assert_macros.svh, path_stack_wildcard_search
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module psws_checker #(
  parameter int unsigned PATH_DEPTH = psws_pkg::PATH_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rsp_valid_i,
  input  wire logic                           rsp_ready_i,
  input  wire logic                           rsp_found_i,
  input  wire logic [psws_pkg::FIELD_W-1:0]   rsp_first_i,
  input  wire logic [psws_pkg::FIELD_W-1:0]   rsp_second_i,
  input  wire logic [psws_pkg::DEPTH_W-1:0]   rsp_depth_i,
  input  wire logic [psws_pkg::STAT_W-1:0]    rsp_status_i
);
  import psws_pkg::*;

  localparam logic [DEPTH_W-1:0] FullDepth = DEPTH_W'(PATH_DEPTH);

  // a stalled beat stays
  `PSWS_ASSERT(a_rsp_hold, clk_i, rst_ni,
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)

  // a stalled beat keeps its payload
  `PSWS_ASSERT(a_rsp_stable, clk_i, rst_ni,
    (rsp_valid_i && !rsp_ready_i) |=>
      $stable({rsp_found_i, rsp_first_i, rsp_second_i, rsp_depth_i, rsp_status_i}))

  // a hit is never reported with a status other than ok
  `PSWS_NEVER(a_found_status, clk_i, rst_ni,
    rsp_valid_i && rsp_found_i && (rsp_status_i != ST_OK))

  // a rejected push reports a full stack
  `PSWS_ASSERT(a_full_depth, clk_i, rst_ni,
    (rsp_valid_i && (rsp_status_i == ST_FULL)) |-> (rsp_depth_i == FullDepth))

endmodule

bind path_stack_wildcard_search psws_checker #(
  .PATH_DEPTH (PATH_DEPTH)
) u_psws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_found_i  (rsp_o.found),
  .rsp_first_i  (rsp_o.top_first_inst),
  .rsp_second_i (rsp_o.top_second_inst),
  .rsp_depth_i  (rsp_o.stack_depth),
  .rsp_status_i (rsp_o.status)
);

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for path_stack_wildcard_search: directed table, then random bursts
// depends on psws_pkg, psws_if and the path_stack_wildcard_search rtl
`timescale 1ns / 1ps

module tb_top;
  import psws_pkg::*;

  localparam int PATH_N   = PATH_DEPTH_DEF;
  localparam int BACKUP_N = BACKUP_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] top_first;
    logic [FIELD_W-1:0] top_second;
    logic [DEPTH_W-1:0] depth;
    status_e            status;
  } rsp_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
    logic [FIELD_W-1:0] tag;
    bit                 typed;
    rsp_t               want;
  } dir_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_SAVE, MODE_MIX, MODE_NOISE} mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  psws_in_if  req_if ();
  psws_out_if rsp_if ();

  path_stack_wildcard_search u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // path stack mirror
  logic [FIELD_W-1:0] stk_id     [PATH_N];
  logic [FIELD_W-1:0] stk_first  [PATH_N];
  logic [FIELD_W-1:0] stk_second [PATH_N];
  logic [FIELD_W-1:0] stk_tag    [PATH_N];
  logic [31:0]        backup_pair [BACKUP_N];
  int                 stk_count;
  int                 backup_count;

  rsp_t     pending_rsp [$];
  dir_row_t dir_rows [$];
  int       error_count;
  bit       no_idle;

  function automatic rsp_t apply_path_op(logic [OP_W-1:0] op, logic [FIELD_W-1:0] id,
                                         logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] s,
                                         logic [FIELD_W-1:0] t);
    rsp_t r;
    int   top;
    logic [31:0] pair;
    r = '0;
    r.status = ST_OK;
    top = (stk_count > 0) ? stk_count - 1 : 0;
    case (op)
      OP_PUSH: begin
        if (stk_count >= PATH_N) begin
          r.status = ST_FULL;
        end else begin
          stk_id[stk_count]     = id;
          stk_first[stk_count]  = f;
          stk_second[stk_count] = s;
          stk_tag[stk_count]    = t;
          stk_count++;
        end
      end
      OP_POP: begin
        if (stk_count == 0) r.status = ST_EMPTY;
        else stk_count--;
      end
      OP_SEARCH: begin
        for (int k = 0; k < stk_count; k++) begin
          if (stk_id[k] == id && (f == 0 || stk_first[k] == f) &&
              (s == 0 || stk_second[k] == s) && (t == 0 || stk_tag[k] == t))
            r.found = 1'b1;
        end
      end
      OP_SET_FIRST: begin
        if (stk_count == 0) r.status = ST_EMPTY;
        else stk_first[top] = f;
      end
      OP_SET_SECOND: begin
        if (stk_count == 0) r.status = ST_EMPTY;
        else stk_second[top] = s;
      end
      OP_SAVE: begin
        if (stk_count == 0) begin
          r.status = ST_EMPTY;
        end else if (backup_count >= BACKUP_N) begin
          r.status = ST_BACKUP_FULL;
        end else begin
          backup_pair[backup_count] = {stk_first[top], stk_second[top]};
          backup_count++;
        end
      end
      OP_RESTORE: begin
        if (stk_count == 0 || backup_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          backup_count--;
          pair = backup_pair[backup_count];
          stk_first[top]  = pair[31:16];
          stk_second[top] = pair[15:0];
        end
      end
      default: ;
    endcase
    if (stk_count > 0) begin
      r.top_first  = stk_first[stk_count-1];
      r.top_second = stk_second[stk_count-1];
    end
    r.depth = stk_count[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic rsp_t mk_rsp(logic fnd, logic [FIELD_W-1:0] tf, logic [FIELD_W-1:0] ts,
                                  int depth, status_e st);
    rsp_t r;
    r.found      = fnd;
    r.top_first  = tf;
    r.top_second = ts;
    r.depth      = depth[DEPTH_W-1:0];
    r.status     = st;
    return r;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic [FIELD_W-1:0] id, logic [FIELD_W-1:0] f,
                         logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] t, bit typed, rsp_t want);
    dir_row_t row;
    row.op = op;
    row.id = id;
    row.first = f;
    row.second = s;
    row.tag = t;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic logic [FIELD_W-1:0] pick_id();
    int w;
    w = $urandom_range(0, 99);
    if (w < 35) return 16'($signed($urandom_range(0, 4)) - 2);
    if (w < 45) return 16'h8000;
    if (w < 55) return 16'h7fff;
    return 16'($urandom);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_inst();
    int w;
    w = $urandom_range(0, 99);
    if (w < 40) return 16'($urandom_range(1, 4));
    if (w < 50) return '0;
    if (w < 60) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic logic [FIELD_W-1:0] search_field(logic [FIELD_W-1:0] stored);
    int w;
    w = $urandom_range(0, 99);
    if (w < 30) return '0;
    if (w < 40) return pick_inst();
    return stored;
  endfunction

  task automatic gen_random(input mode_e mode, output logic [OP_W-1:0] op,
                            output logic [FIELD_W-1:0] id, output logic [FIELD_W-1:0] f,
                            output logic [FIELD_W-1:0] s, output logic [FIELD_W-1:0] t);
    int w;
    int k;
    w = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (w < 70) op = OP_PUSH;
        else if (w < 80) op = OP_SEARCH;
        else if (w < 85) op = OP_SET_FIRST;
        else if (w < 90) op = OP_SET_SECOND;
        else if (w < 95) op = OP_SAVE;
        else op = OP_POP;
      end
      MODE_DRAIN: begin
        if (w < 60) op = OP_POP;
        else if (w < 75) op = OP_SEARCH;
        else if (w < 85) op = OP_RESTORE;
        else if (w < 92) op = OP_PUSH;
        else op = OP_SET_SECOND;
      end
      MODE_SAVE: begin
        if (w < 55) op = OP_SAVE;
        else if (w < 65) op = OP_SET_FIRST;
        else if (w < 75) op = OP_SET_SECOND;
        else if (w < 85) op = OP_RESTORE;
        else if (w < 95) op = OP_SEARCH;
        else op = OP_PUSH;
      end
      MODE_MIX: begin
        if (w < 20) op = OP_PUSH;
        else if (w < 35) op = OP_POP;
        else if (w < 65) op = OP_SEARCH;
        else if (w < 73) op = OP_SET_FIRST;
        else if (w < 81) op = OP_SET_SECOND;
        else if (w < 90) op = OP_SAVE;
        else if (w < 99) op = OP_RESTORE;
        else op = OP_UNUSED;
      end
      default: op = 3'($urandom_range(0, 7));
    endcase
    id = pick_id();
    f  = pick_inst();
    s  = pick_inst();
    t  = pick_inst();
    if (mode == MODE_NOISE) begin
      id = 16'($urandom);
      f  = 16'($urandom);
      s  = 16'($urandom);
      t  = 16'($urandom);
    end else if (op == OP_SEARCH && stk_count > 0 && $urandom_range(0, 99) < 70) begin
      // aim at a live entry, some fields wildcarded or perturbed
      k  = $urandom_range(0, stk_count - 1);
      id = stk_id[k];
      f  = search_field(stk_first[k]);
      s  = search_field(stk_second[k]);
      t  = search_field(stk_tag[k]);
    end
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] id,
                         input logic [FIELD_W-1:0] f, input logic [FIELD_W-1:0] s,
                         input logic [FIELD_W-1:0] t, input bit typed, input rsp_t want);
    int   gap;
    rsp_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.operation   <= op;
    req_if.entry_id    <= id;
    req_if.first_inst  <= f;
    req_if.second_inst <= s;
    req_if.clause_tag  <= t;
    req_if.valid       <= 1'b1;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    pred = apply_path_op(op, id, f, s, t);
    pending_rsp.insert(pending_rsp.size(), typed ? want : pred);
    @(negedge clk_i);
  endtask

  // response side: random back-pressure and in-order checking
  initial begin
    int   stall;
    rsp_t exp_rsp;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected response beat, expected none, actual depth %0d status %0d",
                   $time, rsp_if.stack_depth, rsp_if.status);
          error_count++;
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (rsp_if.found !== exp_rsp.found) begin
            $display("%0t: found mismatch, expected %0d actual %0d",
                     $time, exp_rsp.found, rsp_if.found);
            error_count++;
          end
          if (rsp_if.top_first_inst !== exp_rsp.top_first) begin
            $display("%0t: top_first_inst mismatch, expected %h actual %h",
                     $time, exp_rsp.top_first, rsp_if.top_first_inst);
            error_count++;
          end
          if (rsp_if.top_second_inst !== exp_rsp.top_second) begin
            $display("%0t: top_second_inst mismatch, expected %h actual %h",
                     $time, exp_rsp.top_second, rsp_if.top_second_inst);
            error_count++;
          end
          if (rsp_if.stack_depth !== exp_rsp.depth) begin
            $display("%0t: stack_depth mismatch, expected %0d actual %0d",
                     $time, exp_rsp.depth, rsp_if.stack_depth);
            error_count++;
          end
          if (rsp_if.status !== exp_rsp.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, exp_rsp.status, rsp_if.status);
            error_count++;
          end
        end
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      @(negedge clk_i);
      rsp_if.ready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] id, f, s, t;
    mode_e              mode;
    int                 burst;
    int                 done_items;
    rsp_t               none;

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_PUSH;
    req_if.entry_id    = '0;
    req_if.first_inst  = '0;
    req_if.second_inst = '0;
    req_if.clause_tag  = '0;
    rsp_if.ready       = 1'b0;
    error_count        = 0;
    no_idle            = 1'b0;
    stk_count          = 0;
    backup_count       = 0;
    none               = '0;

    // everything on an empty stack, then extremes and save/restore
    add_row(OP_POP,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_EMPTY));
    add_row(OP_SEARCH,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_OK));
    add_row(OP_SET_FIRST,  16'h0001, 16'h0005, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_EMPTY));
    add_row(OP_SET_SECOND, 16'h0001, 16'h0000, 16'h0005, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_EMPTY));
    add_row(OP_SAVE,       16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_EMPTY));
    add_row(OP_RESTORE,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_EMPTY));
    add_row(OP_UNUSED,     16'hffff, 16'hffff, 16'hffff, 16'hffff, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_OK));
    add_row(OP_PUSH,       16'h8000, 16'hffff, 16'hffff, 16'hffff, 1,
            mk_rsp(0, 16'hffff, 16'hffff, 1, ST_OK));
    add_row(OP_PUSH,       16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 2, ST_OK));
    add_row(OP_PUSH,       16'h0000, 16'h0001, 16'h0002, 16'h0003, 1,
            mk_rsp(0, 16'h0001, 16'h0002, 3, ST_OK));
    add_row(OP_SEARCH,     16'h8000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(1, 16'h0001, 16'h0002, 3, ST_OK));
    add_row(OP_SEARCH,     16'h8000, 16'hffff, 16'hffff, 16'hffff, 1,
            mk_rsp(1, 16'h0001, 16'h0002, 3, ST_OK));
    add_row(OP_SEARCH,     16'h8000, 16'hfffe, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0001, 16'h0002, 3, ST_OK));
    add_row(OP_SEARCH,     16'h0000, 16'h0000, 16'h0002, 16'h0000, 0, none);
    add_row(OP_SEARCH,     16'h7fff, 16'h0001, 16'h0000, 16'h0000, 0, none);
    add_row(OP_RESTORE,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0001, 16'h0002, 3, ST_EMPTY));
    add_row(OP_SAVE,       16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0001, 16'h0002, 3, ST_OK));
    add_row(OP_SET_FIRST,  16'h0000, 16'habcd, 16'h0000, 16'h0000, 0, none);
    add_row(OP_SET_SECOND, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 0, none);
    add_row(OP_RESTORE,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0001, 16'h0002, 3, ST_OK));
    add_row(OP_POP,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 2, ST_OK));
    add_row(OP_POP,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'hffff, 16'hffff, 1, ST_OK));
    add_row(OP_SAVE,       16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, none);
    add_row(OP_POP,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_OK));
    add_row(OP_SEARCH,     16'h8000, 16'h0000, 16'h0000, 16'h0000, 1,
            mk_rsp(0, 16'h0000, 16'h0000, 0, ST_OK));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].id, dir_rows[i].first, dir_rows[i].second,
              dir_rows[i].tag, dir_rows[i].typed, dir_rows[i].want);
    end

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mode = MODE_FILL;
        3, 4:    mode = MODE_DRAIN;
        5, 6:    mode = MODE_SAVE;
        7, 8:    mode = MODE_MIX;
        default: mode = MODE_NOISE;
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(20, 120);
      for (int n = 0; n < burst && done_items < RANDOM_ITEMS; n++) begin
        gen_random(mode, op, id, f, s, t);
        send_op(op, id, f, s, t, 0, none);
        done_items++;
      end
    end
    no_idle = 1'b0;
    req_if.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
